// File: rtl/gesture_hold_confirm_gate_unit_macros.svh
// Assertion macros used by the gesture gate checker.
`ifndef GESTURE_HOLD_CONFIRM_GATE_UNIT_MACROS_SVH
`define GESTURE_HOLD_CONFIRM_GATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define GHCG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define GHCG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ghcg_pkg.sv
// Types and constants for the gesture hold confirm gate.
`default_nettype none

package ghcg_pkg;

   localparam int TIME_BITS      = 32;
   localparam int HOLD_BITS      = 16;
   localparam int GESTURE_BITS   = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_ACTIONS    = 4;
   localparam int ACTION_SEL_BITS = $clog2(NUM_ACTIONS);
   localparam int REQ_PAD_BITS   = 7;

   localparam logic [GESTURE_BITS-1:0] NO_GESTURE          = 3'd0;
   localparam logic [GESTURE_BITS-1:0] GESTURE_ESTOP       = 3'd0;
   localparam logic [GESTURE_BITS-1:0] GESTURE_FIRST_ACTION = 3'd1;
   localparam logic [GESTURE_BITS-1:0] GESTURE_LAST_ACTION = 3'd4;

   localparam logic [HOLD_BITS-1:0] LOST_GRACE_RESET = 16'd1000;
   localparam logic [HOLD_BITS-1:0] HOLD_MS_RESET    = 16'd500;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LOST_GRACE = 3'd0,
      REG_HOLD_ONE   = 3'd1,
      REG_HOLD_TWO   = 3'd2,
      REG_HOLD_THREE = 3'd3,
      REG_HOLD_FOUR  = 3'd4
   } reg_index_type;

   // Request word, last field in the low bits.
   typedef struct packed {
      logic [REQ_PAD_BITS-1:0] pad;
      time_type                now_ms;
      logic                    controller_accepts;
      logic                    action_busy;
      logic                    side_effects_allowed;
      logic                    hand_present;
      logic                    hand_stable;
      logic                    decision_ready;
      logic [GESTURE_BITS-1:0] gesture_code;
   } req_type;

   // Response word, last field in the low bits.
   typedef struct packed {
      time_type                candidate_since_ms;
      logic [GESTURE_BITS-1:0] candidate_gesture;
      logic [GESTURE_BITS-1:0] fired_gesture;
      logic                    fire;
      logic                    abort_request;
   } rsp_type;

   typedef struct packed {
      time_type                lost_start;
      logic                    lost_valid;
      logic [GESTURE_BITS-1:0] candidate;
      time_type                hold_start;
      logic                    hold_valid;
      logic [GESTURE_BITS-1:0] last_fired;
   } gate_state_type;

   typedef struct packed {
      logic [HOLD_BITS-1:0]                   lost_grace_ms;
      logic [NUM_ACTIONS-1:0][HOLD_BITS-1:0]  hold_ms;
   } gate_cfg_type;

endpackage

`default_nettype wire

// File: rtl/gesture_hold_confirm_gate_unit.sv
// Top level of the gesture hold confirm gate.
//
//   channel | direction | payload                               | handshake
//   --------+-----------+---------------------------------------+--------------------
//   req     | in        | 48-bit classifier decision            | req_tvalid/tready
//   rsp     | out       | 40-bit abort/fire/candidate result    | rsp_tvalid/tready
//   csr     | in        | 3-bit register index, 16-bit data     | csr_valid/ready
//
// One transaction per cycle sustained while rsp is not stalled; rsp_tvalid rises once its
// request has passed the input register and then the result register. Reset (synchronous,
// high) loads the register defaults and clears the gate state. A stall on rsp holds the
// result register; the input register still drains into it once that frees, so req_tready
// only drops when both stages are full and rsp is stalled.
`default_nettype none

module gesture_hold_confirm_gate_unit
   import ghcg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // [2:0] gesture_code, [3] decision_ready, [4] hand_stable, [5] hand_present,
   // [6] side_effects_allowed, [7] action_busy, [8] controller_accepts,
   // [40:9] now_ms, [47:41] zero
   input  wire logic [$bits(req_type)-1:0] req_tdata,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [0] abort_request, [1] fire, [4:2] fired_gesture, [7:5] candidate_gesture,
   // [39:8] candidate_since_ms
   output      logic [$bits(rsp_type)-1:0] rsp_tdata,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [HOLD_BITS-1:0]      csr_data
);

   req_type        req_ff;
   logic           req_vld_ff;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_vld_ff;
   gate_state_type state_ff;
   gate_state_type state_in;
   gate_cfg_type   cfg_ff;
   logic           advance;
   logic           req_take;

   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

   ghcg_core u_core (
      .req        (req_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lost_grace_ms <= LOST_GRACE_RESET;
         cfg_ff.hold_ms       <= {NUM_ACTIONS{HOLD_MS_RESET}};
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_LOST_GRACE: cfg_ff.lost_grace_ms <= csr_data;
            REG_HOLD_ONE:   cfg_ff.hold_ms[0]    <= csr_data;
            REG_HOLD_TWO:   cfg_ff.hold_ms[1]    <= csr_data;
            REG_HOLD_THREE: cfg_ff.hold_ms[2]    <= csr_data;
            REG_HOLD_FOUR:  cfg_ff.hold_ms[3]    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         if (req_take) begin
            req_vld_ff <= 1'b1;
         end else if (advance) begin
            req_vld_ff <= 1'b0;
         end

         if (advance) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers: load on transaction, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_type'(req_tdata);
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ghcg_core.sv
// Decision logic: next gate state and response for one request.
`default_nettype none

module ghcg_core
   import ghcg_pkg::*;
(
   input  req_type        req,
   input  gate_state_type state,
   input  gate_cfg_type   cfg,
   output gate_state_type state_next,
   output rsp_type        rsp
);

   time_type                   lost_base;
   time_type                   hold_base;
   time_type                   lost_elapsed;
   time_type                   hold_elapsed;
   logic [ACTION_SEL_BITS-1:0] hold_sel;
   logic [HOLD_BITS-1:0]       hold_limit;
   logic [GESTURE_BITS-1:0]    gesture;
   logic [GESTURE_BITS-1:0]    confirmed;
   logic [GESTURE_BITS-1:0]    fired_ref;
   logic                       lost;

   assign gesture      = req.gesture_code;
   // A timer that has not started yet starts at this request's time.
   assign lost_base    = state.lost_valid ? state.lost_start : req.now_ms;
   assign hold_base    = state.hold_valid ? state.hold_start : req.now_ms;
   assign lost_elapsed = req.now_ms - lost_base;
   assign hold_elapsed = req.now_ms - hold_base;
   assign hold_sel     = ACTION_SEL_BITS'(gesture - GESTURE_FIRST_ACTION);
   assign hold_limit   = cfg.hold_ms[hold_sel];

   always_comb begin
      state_next = state;
      rsp        = '0;
      confirmed  = NO_GESTURE;
      fired_ref  = NO_GESTURE;
      lost       = 1'b0;

      if (!req.decision_ready || gesture > GESTURE_LAST_ACTION || !req.hand_stable) begin
         state_next.last_fired = NO_GESTURE;
      end else if (gesture == GESTURE_ESTOP) begin
         rsp.abort_request     = req.side_effects_allowed;
         state_next.last_fired = NO_GESTURE;
      end else if (!req.side_effects_allowed) begin
         state_next.last_fired = NO_GESTURE;
      end else begin
         if (req.hand_present) begin
            state_next.lost_valid = 1'b0;
         end else begin
            state_next.lost_start = lost_base;
            state_next.lost_valid = 1'b1;
            lost = lost_elapsed >= TIME_BITS'(cfg.lost_grace_ms);
         end

         if (lost) begin
            state_next.candidate  = NO_GESTURE;
            state_next.hold_start = '0;
            state_next.hold_valid = 1'b0;
         end else if (gesture != state.candidate) begin
            state_next.candidate  = gesture;
            state_next.hold_start = req.now_ms;
            state_next.hold_valid = 1'b1;
         end else begin
            state_next.hold_start = hold_base;
            state_next.hold_valid = 1'b1;
            if (hold_elapsed >= TIME_BITS'(hold_limit)) begin
               confirmed = gesture;
            end
         end

         // Drop the fired mark once the confirmation lapses.
         fired_ref = (gesture != confirmed) ? NO_GESTURE : state.last_fired;
         state_next.last_fired = fired_ref;

         if (confirmed != NO_GESTURE && confirmed != fired_ref && !req.action_busy) begin
            rsp.fire          = 1'b1;
            rsp.fired_gesture = confirmed;
            if (req.controller_accepts) begin
               state_next.last_fired = confirmed;
            end
         end
      end

      rsp.candidate_gesture  = state_next.candidate;
      rsp.candidate_since_ms = state_next.hold_valid ? state_next.hold_start : '0;
   end

endmodule

`default_nettype wire

// File: rtl/ghcg_checker.sv
// Port-level checks on the gesture gate result stream, bound to the top level.
`default_nettype none

`include "gesture_hold_confirm_gate_unit_macros.svh"

module ghcg_checker
   import ghcg_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [$bits(rsp_type)-1:0] rsp_tdata
);

   rsp_type rsp_view;

   assign rsp_view = rsp_type'(rsp_tdata);

   `GHCG_ASSERT_NOW(a_fire_matches_candidate, rsp_tvalid && rsp_view.fire, rsp_view.fired_gesture == rsp_view.candidate_gesture && rsp_view.fired_gesture != NO_GESTURE, "fired gesture differs from held candidate")
   `GHCG_ASSERT_NOW(a_no_fire_no_gesture, rsp_tvalid && !rsp_view.fire, rsp_view.fired_gesture == NO_GESTURE, "fired gesture set without fire")
   `GHCG_ASSERT_NOW(a_abort_excludes_fire, rsp_tvalid && rsp_view.abort_request, !rsp_view.fire, "abort and fire in one result")
   `GHCG_ASSERT_NOW(a_no_candidate_no_time, rsp_tvalid && rsp_view.candidate_gesture == NO_GESTURE, rsp_view.candidate_since_ms == '0, "hold time kept without a candidate")
   `GHCG_ASSERT_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

endmodule

bind gesture_hold_confirm_gate_unit ghcg_checker u_ghcg_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for the gesture hold confirm gate: directed and random stream traffic vs. a predictor.
`timescale 1ns / 1ps

module tb_top;
   import ghcg_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS = 60;
   localparam int ITEMS_PER_SETTING = 370;
   localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;
   localparam int IDLE_NONE = 0;
   localparam int IDLE_LIGHT = 1;
   localparam int IDLE_HEAVY = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [$bits(req_type)-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [$bits(rsp_type)-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_LOST_GRACE;
   logic [HOLD_BITS-1:0] csr_data = '0;

   gesture_hold_confirm_gate_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the registers and the gate state.
   logic [HOLD_BITS-1:0] grace_limit = LOST_GRACE_RESET;
   logic [HOLD_BITS-1:0] hold_limit [1:NUM_ACTIONS] = '{default: HOLD_MS_RESET};
   time_type lost_since = '0;
   logic lost_armed = 1'b0;
   logic [GESTURE_BITS-1:0] hold_gesture = NO_GESTURE;
   time_type hold_since = '0;
   logic hold_armed = 1'b0;
   logic [GESTURE_BITS-1:0] last_sent = NO_GESTURE;

   req_type decision_queue[$];
   rsp_type gate_results[$];
   time_type frame_ms = '0;
   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int stretch_left [2] = '{0, 0};
   int wait_mode [2] = '{IDLE_NONE, IDLE_NONE};

   function automatic rsp_type predict_gate(input req_type d);
      rsp_type r;
      logic [GESTURE_BITS-1:0] g;
      logic [GESTURE_BITS-1:0] confirmed;
      logic lost;
      r = '0;
      g = d.gesture_code;
      confirmed = NO_GESTURE;
      lost = 1'b0;
      if (!d.decision_ready || g > GESTURE_LAST_ACTION || !d.hand_stable) begin
         last_sent = NO_GESTURE;
      end else if (g == GESTURE_ESTOP) begin
         r.abort_request = d.side_effects_allowed;
         last_sent = NO_GESTURE;
      end else if (!d.side_effects_allowed) begin
         last_sent = NO_GESTURE;
      end else begin
         if (d.hand_present) begin
            lost_armed = 1'b0;
         end else begin
            if (!lost_armed) begin
               lost_since = d.now_ms;
               lost_armed = 1'b1;
            end
            lost = time_type'(d.now_ms - lost_since) >= time_type'(grace_limit);
         end
         if (lost) begin
            hold_gesture = NO_GESTURE;
            hold_since = '0;
            hold_armed = 1'b0;
         end else if (g != hold_gesture) begin
            hold_gesture = g;
            hold_since = d.now_ms;
            hold_armed = 1'b1;
         end else begin
            if (!hold_armed) begin
               hold_since = d.now_ms;
               hold_armed = 1'b1;
            end
            if (time_type'(d.now_ms - hold_since) >= time_type'(hold_limit[g]))
               confirmed = g;
         end
         if (g != confirmed)
            last_sent = NO_GESTURE;
         // Send while idle; a refused send leaves last_sent alone so it repeats.
         if (confirmed != NO_GESTURE && confirmed != last_sent && !d.action_busy) begin
            r.fire = 1'b1;
            r.fired_gesture = confirmed;
            if (d.controller_accepts)
               last_sent = confirmed;
         end
      end
      r.candidate_gesture = hold_gesture;
      r.candidate_since_ms = hold_armed ? hold_since : '0;
      return r;
   endfunction

   function automatic int draw_wait(input int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(8, 60);
         wait_mode[side] = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      end
      stretch_left[side]--;
      case (wait_mode[side])
         IDLE_NONE: return 0;
         IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   task automatic queue_decision(input logic [GESTURE_BITS-1:0] g, input bit rdy, input bit stb,
                                 input bit pres, input bit alw, input bit busy, input bit acc,
                                 input time_type t);
      req_type d;
      d = '0;
      d.gesture_code = g;
      d.decision_ready = rdy;
      d.hand_stable = stb;
      d.hand_present = pres;
      d.side_effects_allowed = alw;
      d.action_busy = busy;
      d.controller_accepts = acc;
      d.now_ms = t;
      decision_queue.push_back(d);
   endtask

   // Advance frame time, with the odd jump, reload or approach to the wrap point.
   task automatic step_frame_time(input int span);
      case ($urandom_range(0, 39))
         0: frame_ms = $urandom;
         1: frame_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * span);
         2: frame_ms = frame_ms + $urandom_range(0, 70000);
         default: frame_ms = frame_ms + $urandom_range(0, span);
      endcase
   endtask

   task automatic queue_random(input int count, input int span);
      int made;
      int len;
      int absent_left;
      logic [GESTURE_BITS-1:0] g;
      bit pres;
      made = 0;
      absent_left = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) < 7) begin
            // well-formed hold run with random detail
            g = GESTURE_BITS'($urandom_range(GESTURE_FIRST_ACTION, GESTURE_LAST_ACTION));
            len = $urandom_range(3, 25);
            for (int k = 0; k < len && made < count; k++) begin
               step_frame_time(span);
               if ($urandom_range(0, 9) == 0)
                  g = GESTURE_BITS'($urandom_range(GESTURE_ESTOP, GESTURE_LAST_ACTION));
               if (absent_left == 0 && $urandom_range(0, 11) == 0)
                  absent_left = $urandom_range(1, 8);
               pres = (absent_left == 0);
               if (absent_left > 0)
                  absent_left--;
               queue_decision(g, $urandom_range(0, 29) != 0, $urandom_range(0, 29) != 0, pres,
                              $urandom_range(0, 29) != 0, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) != 0, frame_ms);
               made++;
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len && made < count; k++) begin
               step_frame_time(span);
               queue_decision(GESTURE_BITS'($urandom_range(0, 7)),
                              $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                              $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                              $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, frame_ms);
               made++;
            end
         end
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [HOLD_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_LOST_GRACE)
         grace_limit = value;
      else
         hold_limit[int'(idx)] = value;
   endtask

   task automatic set_limits(input logic [HOLD_BITS-1:0] grace, input logic [HOLD_BITS-1:0] h1,
                             input logic [HOLD_BITS-1:0] h2, input logic [HOLD_BITS-1:0] h3,
                             input logic [HOLD_BITS-1:0] h4);
      write_reg(REG_LOST_GRACE, grace);
      write_reg(REG_HOLD_ONE, h1);
      write_reg(REG_HOLD_TWO, h2);
      write_reg(REG_HOLD_THREE, h3);
      write_reg(REG_HOLD_FOUR, h4);
   endtask

   // Wait until every decision is sent and every result checked, then let the pipe empty.
   // Sample away from the rising edge so the driver and monitor updates have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (decision_queue.size() != 0 || req_tvalid || gate_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Request driver: predict on every accepted transaction, then load the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            gate_results.push_back(predict_gate(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (decision_queue.size() != 0) begin
               req_tdata <= decision_queue.pop_front();
               req_tvalid <= 1'b1;
               gap_left = draw_wait(SIDE_REQ);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (gate_results.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
            end else begin
               want = gate_results.pop_front();
               check_field("abort_request", 32'(want.abort_request), 32'(got.abort_request));
               check_field("fire", 32'(want.fire), 32'(got.fire));
               check_field("fired_gesture", 32'(want.fired_gesture), 32'(got.fired_gesture));
               check_field("candidate_gesture", 32'(want.candidate_gesture),
                           32'(got.candidate_gesture));
               check_field("candidate_since_ms", want.candidate_since_ms,
                           got.candidate_since_ms);
            end
            stall_left = draw_wait(SIDE_RSP);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL gesture_hold_confirm_gate_unit");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pass under the reset limits: grace 1000, holds 500.
      queue_decision(3'd1, 1, 1, 1, 1, 0, 1, 32'd0);
      queue_decision(3'd1, 1, 1, 1, 1, 0, 1, 32'd499);
      queue_decision(3'd1, 1, 1, 1, 1, 1, 1, 32'd500);
      queue_decision(3'd1, 1, 1, 1, 1, 0, 0, 32'd510);
      queue_decision(3'd1, 1, 1, 1, 1, 0, 1, 32'd520);
      queue_decision(3'd1, 1, 1, 1, 1, 0, 1, 32'd530);
      queue_decision(3'd1, 0, 1, 1, 1, 0, 1, 32'd540);
      queue_decision(3'd1, 1, 1, 1, 1, 0, 1, 32'd550);
      queue_decision(3'd5, 1, 1, 1, 1, 0, 1, 32'd560);
      queue_decision(3'd6, 1, 1, 1, 1, 0, 1, 32'd570);
      queue_decision(3'd7, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
      queue_decision(GESTURE_ESTOP, 1, 1, 1, 1, 0, 1, 32'd600);
      queue_decision(GESTURE_ESTOP, 1, 1, 1, 0, 0, 1, 32'd605);
      queue_decision(GESTURE_ESTOP, 1, 0, 1, 1, 0, 1, 32'd610);
      queue_decision(3'd2, 1, 1, 1, 0, 0, 1, 32'd620);
      queue_decision(3'd2, 1, 0, 1, 1, 0, 1, 32'd630);
      // hand gone: hold survives inside the grace time, then drops
      queue_decision(3'd2, 1, 1, 0, 1, 0, 1, 32'd1000);
      queue_decision(3'd2, 1, 1, 0, 1, 0, 1, 32'd1999);
      queue_decision(3'd2, 1, 1, 0, 1, 0, 1, 32'd2000);
      // hold across the time wrap
      queue_decision(3'd3, 1, 1, 1, 1, 0, 1, 32'hFFFF_FF00);
      queue_decision(3'd3, 1, 1, 1, 1, 0, 1, 32'h0000_00F4);
      queue_decision(3'd4, 1, 1, 1, 1, 0, 1, 32'h0000_0100);
      queue_decision(GESTURE_ESTOP, 0, 0, 0, 0, 0, 0, 32'd0);
      queue_random(ITEMS_PER_SETTING, 120);
      wait_drained();

      set_limits('0, '0, '0, '0, '0);
      queue_random(ITEMS_PER_SETTING, 40);
      wait_drained();

      set_limits(HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX);
      queue_random(ITEMS_PER_SETTING, 9000);
      wait_drained();

      set_limits(HOLD_BITS'($urandom_range(0, 300)), HOLD_BITS'($urandom_range(0, 300)),
                 HOLD_BITS'($urandom_range(0, 300)), HOLD_BITS'($urandom_range(0, 300)),
                 HOLD_BITS'($urandom_range(0, 300)));
      queue_random(ITEMS_PER_SETTING, 60);
      wait_drained();

      set_limits(HOLD_MAX, HOLD_BITS'($urandom_range(0, 1000)),
                 HOLD_BITS'($urandom_range(0, 1000)), HOLD_BITS'($urandom_range(0, 1000)),
                 HOLD_BITS'($urandom_range(0, 1000)));
      queue_random(ITEMS_PER_SETTING, 400);
      wait_drained();

      if (error_count == 0 && gate_results.size() == 0) begin
         $display("PASS gesture_hold_confirm_gate_unit");
      end else begin
         $display("FAIL gesture_hold_confirm_gate_unit");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/ghcg_pkg.sv
rtl/ghcg_core.sv
rtl/gesture_hold_confirm_gate_unit.sv
rtl/ghcg_checker.sv
tb/sv/tb_top.sv
